@@ rtl/core/hsp_pkg.sv @@
// Shared constants and helpers for the hexagonal spiral placement block.
`timescale 1ns / 1ps
`default_nettype none

package hsp_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int RADIUS_W    = 16;
  localparam int CENTRE_W    = 24;
  localparam int POS_W       = 32;
  localparam int LEVEL_W     = 8;
  localparam int RINGPOS_W   = 10;
  localparam int SIN_W       = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd5120;
  localparam logic [15:0]         SIN60_Q16    = 16'd56756;

  typedef logic [2:0]        side_t;
  typedef logic signed [2:0] coef_t;

  // cosine of side * 60 degrees, times two
  function automatic coef_t cos2_of(side_t side);
    coef_t c;
    unique case (side)
      3'd0:    c = 3'sd2;
      3'd1:    c = 3'sd1;
      3'd2:    c = -3'sd1;
      3'd3:    c = -3'sd2;
      3'd4:    c = -3'sd1;
      3'd5:    c = 3'sd1;
      default: c = 3'sd0;
    endcase
    return c;
  endfunction

  // sine of side * 60 degrees, in units of sqrt(3)/2
  function automatic coef_t sin_of(side_t side);
    coef_t c;
    unique case (side)
      3'd1, 3'd2: c = 3'sd1;
      3'd4, 3'd5: c = -3'sd1;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic side_t prev_side(side_t side);
    side_t p;
    p = (side == 3'd0) ? 3'd5 : side - 3'd1;
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hsp_ring.sv @@
// Pipelined ring search: one bit of the largest m with 3m(m+1) < id per stage.
`timescale 1ns / 1ps
`default_nettype none

module hsp_ring #(
  parameter int ID_W   = 16,
  parameter int RING_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [ID_W-1:0]   in_id,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_id,
  output logic [RING_W-1:0] out_m
);

  localparam int PROD_W = 2 * RING_W + 3;
  localparam int CMP_W  = (PROD_W > ID_W) ? PROD_W : ID_W;

  logic              valid_r [RING_W];
  logic [ID_W-1:0]   id_r    [RING_W];
  logic [RING_W-1:0] m_r     [RING_W];

  for (genvar k = 0; k < RING_W; k++) begin : g_stage
    logic              prev_valid;
    logic [ID_W-1:0]   prev_id;
    logic [RING_W-1:0] prev_m;
    logic [RING_W-1:0] cand;
    logic [CMP_W-1:0]  tri_c;
    logic              take;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_id    = in_id;
      assign prev_m     = '0;
    end else begin : g_next
      assign prev_valid = valid_r[k-1];
      assign prev_id    = id_r[k-1];
      assign prev_m     = m_r[k-1];
    end

    assign cand  = prev_m | (RING_W'(1) << (RING_W - 1 - k));
    assign tri_c = CMP_W'(3) * CMP_W'(cand) * (CMP_W'(cand) + CMP_W'(1));
    assign take  = tri_c < CMP_W'(prev_id);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= prev_valid;
      end
      id_r[k] <= prev_id;
      m_r[k]  <= take ? cand : prev_m;
    end
  end

  assign out_valid = valid_r[RING_W-1];
  assign out_id    = id_r[RING_W-1];
  assign out_m     = m_r[RING_W-1];

endmodule

`default_nettype wire

@@ rtl/core/hex_spiral_node_placement.sv @@
// Top level: places numbered nodes on a hexagonal spiral around a centre.
//
// Usage
//   Input: drive in_node_number and raise start; the node is taken at every
//   rising edge with start high and busy low. busy is low except in reset, so
//   one node can be taken in every cycle.
//   Result: out_valid is high for exactly one cycle with out_x_pos, out_y_pos
//   (signed, 8 fraction bits), out_ring_level and out_ring_position. Results
//   leave in the order the nodes came in; the receiver cannot stall them.
//   Configuration: cfg_index selects radius, centre x or centre y; cfg_data is
//   written at an edge with cfg_valid high (cfg_ready is always high). Write
//   only while no node is in flight.
// Pipeline
//   One stage per bit of the ring search, one stage for the ring offset,
//   three divide steps for side and step, then multiply, combine, scale and
//   round stages.
//   Throughput is one node per cycle.
// Reset
//   Synchronous reset clears the pipeline valid bits and loads radius 20.0
//   and a centre at the origin; nodes in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module hex_spiral_node_placement #(
  parameter int ID_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ID_WIDTH-1:0]                 in_node_number,
  output logic                                out_valid,
  output logic signed [hsp_pkg::POS_W-1:0]    out_x_pos,
  output logic signed [hsp_pkg::POS_W-1:0]    out_y_pos,
  output logic [hsp_pkg::LEVEL_W-1:0]         out_ring_level,
  output logic [hsp_pkg::RINGPOS_W-1:0]       out_ring_position,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RING_W = (ID_WIDTH + 1) / 2;
  localparam int PROD_W = 2 * RING_W + 3 + ID_WIDTH;
  localparam int IDX_W  = RING_W + 3;
  localparam int A_W    = hsp_pkg::RADIUS_W + RING_W;
  localparam int SX_W   = A_W + 2;
  localparam int PY_W   = SX_W + hsp_pkg::SIN_W;
  localparam int POS_W  = hsp_pkg::POS_W;

  // configuration registers
  logic [hsp_pkg::RADIUS_W-1:0]        radius_r;
  logic signed [hsp_pkg::CENTRE_W-1:0] centre_x_r;
  logic signed [hsp_pkg::CENTRE_W-1:0] centre_y_r;

  assign cfg_ready = 1'b1;
  assign busy      = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= hsp_pkg::RADIUS_RESET;
      centre_x_r <= '0;
      centre_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hsp_pkg::REG_RADIUS:   radius_r   <= cfg_data[hsp_pkg::RADIUS_W-1:0];
        hsp_pkg::REG_CENTRE_X: centre_x_r <= signed'(cfg_data);
        hsp_pkg::REG_CENTRE_Y: centre_y_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // ring search
  logic                rg_valid;
  logic [ID_WIDTH-1:0] rg_id;
  logic [RING_W-1:0]   rg_m;

  hsp_ring #(
    .ID_W   (ID_WIDTH),
    .RING_W (RING_W)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_id     (in_node_number),
    .out_valid (rg_valid),
    .out_id    (rg_id),
    .out_m     (rg_m)
  );

  // stage 1: ring number and index within the ring
  logic [RING_W:0]   m_inc;
  logic [PROD_W-1:0] tri_c;
  logic [PROD_W-1:0] idx_c;
  logic              rg_zero;

  assign rg_zero = (rg_id == '0);
  assign m_inc   = {1'b0, rg_m} + (RING_W+1)'(1);
  assign tri_c   = PROD_W'(3) * PROD_W'(rg_m) * PROD_W'(m_inc);
  assign idx_c   = PROD_W'(rg_id) - tri_c - PROD_W'(1);

  logic              s1_valid_r, s1_zero_r;
  logic [RING_W-1:0] s1_n_r;
  logic [IDX_W-1:0]  s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= rg_valid;
    end
    s1_zero_r <= rg_zero;
    s1_n_r    <= rg_zero ? '0 : RING_W'(m_inc);
    s1_idx_r  <= rg_zero ? '0 : IDX_W'(idx_c);
  end

  // stages 2 to 4: side = idx / n, step = idx mod n, one quotient bit each
  logic              s2_valid_r, s2_zero_r, s2_q_r;
  logic [RING_W-1:0] s2_n_r;
  logic [IDX_W-1:0]  s2_idx_r, s2_rem_r;
  logic [IDX_W-1:0]  n4_c;

  assign n4_c = IDX_W'({s1_n_r, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_zero_r <= s1_zero_r;
    s2_n_r    <= s1_n_r;
    s2_idx_r  <= s1_idx_r;
    s2_q_r    <= s1_idx_r >= n4_c;
    s2_rem_r  <= (s1_idx_r >= n4_c) ? s1_idx_r - n4_c : s1_idx_r;
  end

  logic              s3_valid_r, s3_zero_r;
  logic [1:0]        s3_q_r;
  logic [RING_W-1:0] s3_n_r;
  logic [IDX_W-1:0]  s3_idx_r, s3_rem_r;
  logic [IDX_W-1:0]  n2_c;

  assign n2_c = IDX_W'({s2_n_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_zero_r <= s2_zero_r;
    s3_n_r    <= s2_n_r;
    s3_idx_r  <= s2_idx_r;
    s3_q_r    <= {s2_q_r, s2_rem_r >= n2_c};
    s3_rem_r  <= (s2_rem_r >= n2_c) ? s2_rem_r - n2_c : s2_rem_r;
  end

  logic                 s4_valid_r, s4_zero_r;
  hsp_pkg::side_t       s4_u_r;
  logic [RING_W-1:0]    s4_n_r;
  logic [IDX_W-1:0]     s4_idx_r, s4_rem_r;
  logic [IDX_W-1:0]     n1_c;

  assign n1_c = IDX_W'(s3_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_zero_r <= s3_zero_r;
    s4_n_r    <= s3_n_r;
    s4_idx_r  <= s3_idx_r;
    s4_u_r    <= {s3_q_r, s3_rem_r >= n1_c};
    s4_rem_r  <= (s3_rem_r >= n1_c) ? s3_rem_r - n1_c : s3_rem_r;
  end

  // stage 5: radius times step counts along the two ring vectors
  logic [RING_W-1:0] v_c;
  assign v_c = RING_W'(s4_rem_r);

  logic                 s5_valid_r, s5_zero_r;
  hsp_pkg::side_t       s5_u_r;
  logic [IDX_W-1:0]     s5_idx_r;
  logic [A_W-1:0]       s5_a_r, s5_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
    s5_zero_r <= s4_zero_r;
    s5_u_r    <= s4_u_r;
    s5_idx_r  <= s4_idx_r;
    s5_a_r    <= A_W'(radius_r) * A_W'(v_c);
    s5_b_r    <= A_W'(radius_r) * A_W'(s4_n_r - v_c);
  end

  // stage 6: combine with the unit vector coefficients
  function automatic logic signed [SX_W-1:0] scale_term(logic [A_W-1:0] mag,
                                                         hsp_pkg::coef_t coef);
    logic signed [SX_W-1:0] s;
    logic signed [SX_W-1:0] r;
    s = signed'(SX_W'(mag));
    unique case (coef)
      3'sd2:   r = s <<< 1;
      3'sd1:   r = s;
      -3'sd1:  r = -s;
      -3'sd2:  r = -(s <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  hsp_pkg::side_t ub_c;
  assign ub_c = hsp_pkg::prev_side(s5_u_r);

  logic                   s6_valid_r, s6_zero_r;
  logic [IDX_W-1:0]       s6_idx_r;
  logic signed [SX_W-1:0] s6_sx_r, s6_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
    s6_zero_r <= s5_zero_r;
    s6_idx_r  <= s5_idx_r;
    s6_sx_r   <= scale_term(s5_a_r, hsp_pkg::cos2_of(s5_u_r))
               + scale_term(s5_b_r, hsp_pkg::cos2_of(ub_c));
    s6_sy_r   <= scale_term(s5_a_r, hsp_pkg::sin_of(s5_u_r))
               + scale_term(s5_b_r, hsp_pkg::sin_of(ub_c));
  end

  // stage 7: halve x with rounding, scale y by sin 60
  logic signed [hsp_pkg::SIN_W-1:0] sin60_c;
  assign sin60_c = signed'({1'b0, hsp_pkg::SIN60_Q16});

  logic                   s7_valid_r, s7_zero_r;
  logic [IDX_W-1:0]       s7_idx_r;
  logic signed [SX_W-1:0] s7_ox_r;
  logic signed [PY_W-1:0] s7_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else begin
      s7_valid_r <= s6_valid_r;
    end
    s7_zero_r <= s6_zero_r;
    s7_idx_r  <= s6_idx_r;
    s7_ox_r   <= (s6_sx_r + SX_W'(1)) >>> 1;
    s7_py_r   <= PY_W'(s6_sy_r) * PY_W'(sin60_c);
  end

  // stage 8: round y, add centre, drive result
  logic signed [PY_W-1:0]  oy_c;
  logic signed [POS_W-1:0] x_c, y_c;

  assign oy_c = (s7_py_r + PY_W'(32768)) >>> 16;
  assign x_c  = POS_W'(centre_x_r) + POS_W'(s7_ox_r);
  assign y_c  = POS_W'(centre_y_r) + POS_W'(oy_c);

  logic                        out_valid_r, out_zero_r;
  logic signed [POS_W-1:0]     out_x_r, out_y_r;
  logic [hsp_pkg::LEVEL_W-1:0] out_level_r;
  logic [hsp_pkg::RINGPOS_W-1:0] out_pos_r;
  logic [RING_W-1:0]           n6_r, n7_r;
  logic [RING_W-1:0]           n5_r;

  // carry ring number alongside the arithmetic stages
  always_ff @(posedge clk) begin
    n5_r <= s4_n_r;
    n6_r <= n5_r;
    n7_r <= n6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s7_valid_r;
    end
    out_zero_r  <= s7_zero_r;
    out_x_r     <= s7_zero_r ? POS_W'(centre_x_r) : x_c;
    out_y_r     <= s7_zero_r ? POS_W'(centre_y_r) : y_c;
    out_level_r <= hsp_pkg::LEVEL_W'(n7_r);
    out_pos_r   <= hsp_pkg::RINGPOS_W'(s7_idx_r);
  end

  assign out_valid         = out_valid_r;
  assign out_x_pos         = out_x_r;
  assign out_y_pos         = out_y_r;
  assign out_ring_level    = out_level_r;
  assign out_ring_position = out_pos_r;

  a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_zero_r |-> s1_idx_r < IDX_W'(3'd6 * IDX_W'(s1_n_r)))
    else $error("ring index beyond six sides");

  a_side_step: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r && !s4_zero_r |-> s4_u_r < 3'd6 && s4_rem_r < IDX_W'(s4_n_r))
    else $error("side or step out of range");

  a_centre_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_x_r == POS_W'(centre_x_r)
      && out_y_r == POS_W'(centre_y_r) && out_level_r == '0 && out_pos_r == '0)
    else $error("centre node not at centre");

endmodule

`default_nettype wire
